[rtl/chtm_pkg.sv]
`timescale 1ns / 1ps

package chtm_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W       = 3;
  localparam int SLOT_W      = 6;
  localparam int THRESH_W    = 16;
  localparam int SECONDS_W   = 16;
  localparam int CFG_INDEX_W = 8;

  // Parameter defaults
  localparam int MAX_CLIENTS_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HEARTBEAT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WARNING = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KICK    = 8'd1;

  // Reset values of the thresholds
  localparam logic [THRESH_W-1:0] WARNING_RESET = 16'd5;
  localparam logic [THRESH_W-1:0] KICK_RESET    = 16'd10;

  // Report kinds
  localparam logic KIND_LAG  = 1'b0;
  localparam logic KIND_KICK = 1'b1;

  // One report waiting for the output register
  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic                 kind;
    logic [SECONDS_W-1:0] seconds;
  } report_t;

endpackage

[rtl/chtm_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module chtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/client_heartbeat_timeout_monitor.sv]
`timescale 1ns / 1ps

// Heartbeat timeout monitor for up to MAX_CLIENTS client slots.
// Command channel (in_valid/in_ready, command, client_slot): register,
// unregister, heartbeat and clear edit the slot table and give no report.
// A tick walks all slots once, one slot per cycle while the receiver keeps
// up, through the idle-counter RAM (read slot n+1 while slot n is updated
// and written back), and holds in_ready low until it is done; the last
// beat of a tick is registered in the finish state.
// Report channel (out_valid/out_ready): one beat per lagging or kicked
// slot in ascending slot order; last_report marks the final beat of a tick.
// One report is held back until the next is found, so the last one can be
// flagged; a tick with no reports gives no beats.
// When the receiver stalls, the scan pauses on the slot that needs the
// output; nothing is dropped.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write only while the block is idle. Unknown indexes are ignored.
// Reset: all slots empty, thresholds back to warning 5 and kick 10. No
// clearing pass is needed; a counter is always written when its slot
// becomes valid.
module client_heartbeat_timeout_monitor #(
  parameter int MAX_CLIENTS = chtm_pkg::MAX_CLIENTS_DEF,
  parameter int COUNT_WIDTH = chtm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [chtm_pkg::CMD_W-1:0]         command,
  input  logic [chtm_pkg::SLOT_W-1:0]        client_slot,
  // report channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [chtm_pkg::SLOT_W-1:0]        report_slot,
  output logic                               report_kind,
  output logic [chtm_pkg::SECONDS_W-1:0]     idle_seconds,
  output logic                               last_report,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [chtm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [chtm_pkg::THRESH_W-1:0]      cfg_data
);

  localparam int AW    = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int PW    = $clog2(MAX_CLIENTS + 1);
  localparam int CMP_W = (COUNT_WIDTH > chtm_pkg::THRESH_W) ? COUNT_WIDTH
                                                             : chtm_pkg::THRESH_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                    state;
  logic [MAX_CLIENTS-1:0]        slot_valid;
  logic [chtm_pkg::THRESH_W-1:0] warning_threshold;
  logic [chtm_pkg::THRESH_W-1:0] kick_threshold;

  // scan pointer and slot whose counter is on the RAM output
  logic [PW-1:0]                 rptr;
  logic                          proc_valid;
  logic [AW-1:0]                 proc_slot;

  // held-back report
  logic                          pend_valid;
  chtm_pkg::report_t             pend;

  // RAM port signals
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [COUNT_WIDTH-1:0]        ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [COUNT_WIDTH-1:0]        ram_rdata;

  // scan datapath
  logic [COUNT_WIDTH-1:0]        count_inc;
  logic [CMP_W-1:0]              count_cmp;
  logic                          is_kick;
  logic                          is_lag;
  logic                          live;
  logic                          hit;
  logic                          out_free;
  logic                          stall;
  logic                          scan_more;
  logic                          out_load;
  chtm_pkg::report_t             found;

  logic                          in_beat;
  logic                          in_range;
  logic [AW-1:0]                 in_idx;

  chtm_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_CLIENTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign in_range  = ({2'b00, client_slot} < 8'(MAX_CLIENTS));
  assign in_idx    = AW'(client_slot);

  // increment and threshold compare for the slot under update
  assign count_inc = ram_rdata + COUNT_WIDTH'(1);
  assign count_cmp = CMP_W'(count_inc);
  assign is_kick   = (count_cmp == CMP_W'(kick_threshold));
  assign is_lag    = (count_cmp >= CMP_W'(warning_threshold));
  assign live      = proc_valid && slot_valid[proc_slot];
  assign hit       = live && (is_kick || is_lag);
  assign out_free  = !out_valid || out_ready;
  assign stall     = hit && pend_valid && !out_free;
  assign scan_more = (rptr < PW'(MAX_CLIENTS));

  // held-back report moves to the output register this cycle
  assign out_load  = ((state == ST_SCAN) && !stall && hit && pend_valid) ||
                     ((state == ST_FINISH) && pend_valid && out_free);

  always_comb begin
    found.slot    = chtm_pkg::SLOT_W'(proc_slot);
    found.kind    = is_kick ? chtm_pkg::KIND_KICK : chtm_pkg::KIND_LAG;
    found.seconds = chtm_pkg::SECONDS_W'(count_inc);
  end

  // RAM port control: table edits when idle, write-back and read-ahead in scan
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_slot;
    ram_wdata = count_inc;
    ram_re    = 1'b0;
    ram_raddr = AW'(rptr);
    if (state == ST_IDLE) begin
      ram_waddr = in_idx;
      ram_wdata = '0;
      if (in_beat && in_range) begin
        if (command == chtm_pkg::CMD_REGISTER) begin
          ram_we = 1'b1;
        end else if (command == chtm_pkg::CMD_HEARTBEAT) begin
          ram_we = slot_valid[in_idx];
        end
      end
    end else if (state == ST_SCAN && !stall) begin
      ram_we = live;
      ram_re = scan_more;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      warning_threshold <= chtm_pkg::WARNING_RESET;
      kick_threshold    <= chtm_pkg::KICK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == chtm_pkg::REG_WARNING) begin
        warning_threshold <= cfg_data;
      end else if (cfg_index == chtm_pkg::REG_KICK) begin
        kick_threshold <= cfg_data;
      end
    end
  end

  // sequencer, slot table and report queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      rptr       <= '0;
      proc_valid <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            case (command)
              chtm_pkg::CMD_TICK: begin
                state      <= ST_SCAN;
                rptr       <= '0;
                proc_valid <= 1'b0;
              end
              chtm_pkg::CMD_REGISTER: begin
                if (in_range) begin
                  slot_valid[in_idx] <= 1'b1;
                end
              end
              chtm_pkg::CMD_UNREGISTER: begin
                if (in_range) begin
                  slot_valid[in_idx] <= 1'b0;
                end
              end
              chtm_pkg::CMD_CLEAR: begin
                slot_valid <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (hit) begin
              // previous report goes out now that another one follows
              if (pend_valid) begin
                report_slot  <= pend.slot;
                report_kind  <= pend.kind;
                idle_seconds <= pend.seconds;
                last_report  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend       <= found;
            end
            if (scan_more) begin
              proc_valid <= 1'b1;
              proc_slot  <= AW'(rptr);
              rptr       <= rptr + PW'(1);
            end else begin
              proc_valid <= 1'b0;
              state      <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            report_slot  <= pend.slot;
            report_kind  <= pend.kind;
            idle_seconds <= pend.seconds;
            last_report  <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
